// File: rtl/gbc_pkg.sv
package gbc_pkg;

	localparam int NUM_ROUNDS = 32;
	localparam int HALF_W     = 32;
	localparam int BLOCK_W    = 64;
	localparam int NUM_ROWS   = 8;
	localparam int NUM_KEYREG = 4;
	localparam int ROT_L      = 11;

	typedef enum logic [1:0] {
		KIND_ENCRYPT = 2'd0,
		KIND_DECRYPT = 2'd1,
		KIND_LOAD    = 2'd2
	} kind_t;

	typedef logic [NUM_ROWS-1:0][BLOCK_W-1:0] sbox_tbl_t;
	typedef logic [NUM_KEYREG-1:0][BLOCK_W-1:0] key_tbl_t;

	// Encrypt: keys 0..7 three times, then 7..0. Decrypt: 0..7 once, then 7..0 three times.
	function automatic logic [2:0] key_sel(input logic [4:0] rnd, input logic dec);
		logic fwd;
		begin
			fwd = dec ? (rnd < 5'd8) : (rnd < 5'd24);
			key_sel = fwd ? rnd[2:0] : ~rnd[2:0];
		end
	endfunction

	function automatic logic [HALF_W-1:0] subkey(input key_tbl_t keys, input logic [2:0] k);
		logic [BLOCK_W-1:0] w;
		begin
			w = keys[k[2:1]];
			subkey = k[0] ? w[HALF_W-1:0] : w[BLOCK_W-1:HALF_W];
		end
	endfunction

	// Nibble j goes through S-box row j, then rotate left by eleven.
	function automatic logic [HALF_W-1:0] round_f(input logic [HALF_W-1:0] x,
			input sbox_tbl_t rows);
		logic [HALF_W-1:0] s;
		logic [3:0]        nib;
		begin
			s = '0;
			for (int j = 0; j < NUM_ROWS; j++) begin
				nib = x[4*j +: 4];
				s[4*j +: 4] = rows[j][4*nib +: 4];
			end
			round_f = {s[HALF_W-ROT_L-1:0], s[HALF_W-1:HALF_W-ROT_L]};
		end
	endfunction

endpackage

// File: rtl/gost_block_cipher_ecb_top.sv
// The round pipeline has one register per round between the input transaction and
// the output transaction.
// Throughput: one block per cycle while out_ready does not stall; each of the 32 round
// stages holds one block. A row load waits until the round pipeline has drained.
// Reset clears the stage valid bits and the key registers; S-box rows are not reset.
module gost_block_cipher_ecb_top
	import gbc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [BLOCK_W-1:0]   cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           kind,
	input  logic [BLOCK_W-1:0]   data_block,
	input  logic [2:0]           row_index,
	input  logic [BLOCK_W-1:0]   row_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [BLOCK_W-1:0]   result_block
);

	key_tbl_t  key_q;
	sbox_tbl_t sbox_q;

	logic [NUM_ROUNDS:1]  vld_s;
	logic [NUM_ROUNDS:1]  dec_s;
	logic [HALF_W-1:0]    n1_s [1:NUM_ROUNDS];
	logic [HALF_W-1:0]    n2_s [1:NUM_ROUNDS];

	logic [NUM_ROUNDS:1]  adv;
	logic [HALF_W-1:0]    cur_n1 [0:NUM_ROUNDS-1];
	logic [HALF_W-1:0]    cur_n2 [0:NUM_ROUNDS-1];
	logic [NUM_ROUNDS-1:0] cur_dec;

	logic is_load, is_block, pipe_empty, blk_fire, load_fire, out_fire;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			key_q[cfg_index] <= cfg_data;
		end
	end

	assign is_load    = (kind == KIND_LOAD);
	assign is_block   = (kind == KIND_ENCRYPT) || (kind == KIND_DECRYPT);
	assign pipe_empty = ~|vld_s;

	// Stage s may load when it is empty or its contents move on this cycle.
	always_comb begin
		adv[NUM_ROUNDS] = !vld_s[NUM_ROUNDS] || out_ready;
		for (int s = NUM_ROUNDS-1; s >= 1; s--) begin
			adv[s] = !vld_s[s] || adv[s+1];
		end
	end

	// Hold a row load until in-flight blocks have finished with the old rows.
	always_comb begin
		if (is_load) begin
			in_ready = pipe_empty;
		end else if (is_block) begin
			in_ready = adv[1];
		end else begin
			in_ready = 1'b1;
		end
	end

	assign blk_fire  = in_valid && in_ready && is_block;
	assign load_fire = in_valid && in_ready && is_load;
	assign out_fire  = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (load_fire) begin
			sbox_q[row_index] <= row_data;
		end
	end

	always_comb begin
		cur_n1[0]  = data_block[BLOCK_W-1:HALF_W];
		cur_n2[0]  = data_block[HALF_W-1:0];
		cur_dec[0] = (kind == KIND_DECRYPT);
		for (int r = 1; r < NUM_ROUNDS; r++) begin
			cur_n1[r]  = n1_s[r];
			cur_n2[r]  = n2_s[r];
			cur_dec[r] = dec_s[r];
		end
	end

	for (genvar g = 1; g <= NUM_ROUNDS; g++) begin : g_round
		logic [HALF_W-1:0] sk;
		logic [HALF_W-1:0] fval;
		logic              vin;

		assign sk   = subkey(key_q, key_sel(5'(g-1), cur_dec[g-1]));
		assign fval = round_f(cur_n1[g-1] + sk, sbox_q);
		assign vin  = (g == 1) ? blk_fire : vld_s[(g == 1) ? 1 : g-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (adv[g]) begin
				vld_s[g] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[g]) begin
				n1_s[g]  <= fval ^ cur_n2[g-1];
				n2_s[g]  <= cur_n1[g-1];
				dec_s[g] <= cur_dec[g-1];
			end
		end
	end

	assign out_valid    = vld_s[NUM_ROUNDS];
	assign result_block = {n2_s[NUM_ROUNDS], n1_s[NUM_ROUNDS]};

	a_load_on_empty: assert property (@(posedge clk) disable iff (!arst_n)
		load_fire |-> pipe_empty)
		else $error("row load taken with blocks in flight");

	a_load_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		load_fire |=> pipe_empty)
		else $error("block entered together with a row load");

	a_conserve: assert property (@(posedge clk) disable iff (!arst_n)
		(!blk_fire && !out_fire) |=> ($countones(vld_s) == $past($countones(vld_s))))
		else $error("block lost or duplicated in round pipeline");

	a_count_in: assert property (@(posedge clk) disable iff (!arst_n)
		(blk_fire && !out_fire) |=> ($countones(vld_s) == $past($countones(vld_s)) + 1))
		else $error("accepted block not tracked in round pipeline");

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
module tb;
	import gbc_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int NUM_PHASES     = 6;
	localparam int RAND_PER_PHASE = 138;
	localparam int DRAIN_CYCLES   = 48;
	localparam int CYCLE_LIMIT    = 300000;
	localparam int MAX_REPORTS    = 10;

	typedef struct {
		logic [1:0]         op;
		logic [BLOCK_W-1:0] blk;
		logic [2:0]         row;
		logic [BLOCK_W-1:0] entries;
	} cipher_req_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               cfg_valid    = 1'b0;
	logic [1:0]         cfg_index    = '0;
	logic [BLOCK_W-1:0] cfg_data     = '0;
	logic               in_valid     = 1'b0;
	logic [1:0]         kind         = '0;
	logic [BLOCK_W-1:0] data_block   = '0;
	logic [2:0]         row_index    = '0;
	logic [BLOCK_W-1:0] row_data     = '0;
	logic               out_ready    = 1'b0;
	logic               cfg_ready;
	logic               in_ready;
	logic               out_valid;
	logic [BLOCK_W-1:0] result_block;

	cipher_req_t        cipher_reqs[$];
	logic [BLOCK_W-1:0] blocks_due[$];
	cipher_req_t        cur_req;
	key_tbl_t           key_model;
	sbox_tbl_t          sbox_model;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int cycle_count   = 0;
	int n_errors      = 0;
	int n_encrypts    = 0;
	int n_decrypts    = 0;
	int n_loads       = 0;
	int n_ignored     = 0;
	int n_results     = 0;
	int n_key_sets    = 0;

	gost_block_cipher_ecb_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.data_block   (data_block),
		.row_index    (row_index),
		.row_data     (row_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_block (result_block)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic [HALF_W-1:0] round_key(input logic [2:0] k);
		logic [BLOCK_W-1:0] pair;
		pair = key_model[k[2:1]];
		return k[0] ? pair[31:0] : pair[63:32];
	endfunction

	// substitute each nibble through its own row, then rotate left by 11
	function automatic logic [HALF_W-1:0] mix_half(input logic [HALF_W-1:0] x);
		logic [HALF_W-1:0] s;
		logic [3:0] nib;
		s = '0;
		for (int j = 0; j < NUM_ROWS; j++) begin
			nib = x[4*j +: 4];
			s[4*j +: 4] = sbox_model[j][4*nib +: 4];
		end
		return (s << 11) | (s >> 21);
	endfunction

	function automatic logic [BLOCK_W-1:0] gost_ecb_transform(input logic [BLOCK_W-1:0] blk,
			input logic decrypt);
		logic [HALF_W-1:0] n1, n2, t;
		logic [2:0] k;
		n1 = blk[63:32];
		n2 = blk[31:0];
		for (int r = 0; r < NUM_ROUNDS; r++) begin
			if (decrypt)
				k = (r < 8) ? r[2:0] : 3'(7 - (r % 8));
			else
				k = (r < 24) ? r[2:0] : 3'(31 - r);
			t  = mix_half(n1 + round_key(k)) ^ n2;
			n2 = n1;
			n1 = t;
		end
		return {n2, n1};
	endfunction

	function automatic void absorb_req(input cipher_req_t r);
		case (r.op)
			KIND_LOAD: begin
				sbox_model[r.row] = r.entries;
				n_loads++;
			end
			KIND_ENCRYPT, KIND_DECRYPT: begin
				blocks_due.push_back(gost_ecb_transform(r.blk, r.op == KIND_DECRYPT));
				if (r.op == KIND_DECRYPT)
					n_decrypts++;
				else
					n_encrypts++;
			end
			default: n_ignored++;
		endcase
	endfunction

	function automatic logic [BLOCK_W-1:0] pick_block();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return {1'b1, 63'd0};
			3: return 64'd1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic cipher_req_t random_req();
		cipher_req_t r;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 44)
			r.op = KIND_ENCRYPT;
		else if (pick < 88)
			r.op = KIND_DECRYPT;
		else if (pick < 96)
			r.op = KIND_LOAD;
		else
			r.op = KIND_UNUSED;
		r.blk     = pick_block();
		r.row     = 3'($urandom_range(0, NUM_ROWS - 1));
		r.entries = {$urandom, $urandom};
		return r;
	endfunction

	function automatic void queue_req(input logic [1:0] op, input logic [BLOCK_W-1:0] blk,
			input logic [2:0] row, input logic [BLOCK_W-1:0] entries);
		cipher_req_t r;
		r.op      = op;
		r.blk     = blk;
		r.row     = row;
		r.entries = entries;
		cipher_reqs.push_back(r);
	endfunction

	function automatic void flag(input string what, input logic [BLOCK_W-1:0] want,
			input logic [BLOCK_W-1:0] got);
		n_errors++;
		if (n_errors <= MAX_REPORTS)
			$display("[%0t] %s: expected %h, got %h", $realtime, what, want, got);
	endfunction

	// driver: hold the payload until accepted, then advance the model and the queue
	always @(posedge clk) begin : drive
		cipher_req_t nxt;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				key_model[cfg_index] = cfg_data;
			if (in_valid && in_ready)
				absorb_req(cur_req);
			if (!in_valid || in_ready) begin
				if (cipher_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					nxt        = cipher_reqs.pop_front();
					cur_req    = nxt;
					in_valid   <= 1'b1;
					kind       <= nxt.op;
					data_block <= nxt.blk;
					row_index  <= nxt.row;
					row_data   <= nxt.entries;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : watch
		logic [BLOCK_W-1:0] want;
		out_ready <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (blocks_due.size() == 0) begin
				flag("result with nothing outstanding", '0, result_block);
			end else begin
				want = blocks_due.pop_front();
				if (result_block !== want)
					flag("result_block mismatch", want, result_block);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timed out after %0d cycles", cycle_count);
			$display("gost_block_cipher_ecb_top regression: fail");
			$finish;
		end
	end

	task automatic wait_drained();
		while (cipher_reqs.size() != 0 || in_valid || blocks_due.size() != 0)
			@(posedge clk);
		// a trailing row load gives no result, so let the pipeline settle
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_key(input key_tbl_t key);
		@(posedge clk);
		for (int i = 0; i < NUM_KEYREG; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= 2'(i);
			cfg_data  <= key[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		n_key_sets++;
	endtask

	initial begin
		key_tbl_t key;
		int counted;
		cipher_req_t r;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			wait_drained();
			case (phase)
				0: key = '1;
				1: key = '0;
				3: key = {NUM_KEYREG{64'hAAAA_AAAA_5555_5555}};
				default:
					for (int i = 0; i < NUM_KEYREG; i++)
						key[i] = {$urandom, $urandom};
			endcase
			program_key(key);

			@(negedge clk);
			case (phase / 2)
				0: begin send_idle_pct = 25; recv_idle_pct = 75; end
				1: begin send_idle_pct = 75; recv_idle_pct = 25; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase

			if (phase == 0) begin
				// fill every row before the first block, extremes included
				queue_req(KIND_LOAD, '0, 3'd0, '0);
				queue_req(KIND_LOAD, '1, 3'd1, '1);
				for (int i = 2; i < NUM_ROWS; i++)
					queue_req(KIND_LOAD, {$urandom, $urandom}, 3'(i), {$urandom, $urandom});
				queue_req(KIND_ENCRYPT, '0, 3'd0, '0);
				queue_req(KIND_ENCRYPT, '1, 3'd7, '1);
				queue_req(KIND_DECRYPT, '0, 3'd7, '1);
				queue_req(KIND_DECRYPT, '1, 3'd0, '0);
				queue_req(KIND_UNUSED, '1, 3'd7, '1);
				queue_req(KIND_UNUSED, {$urandom, $urandom}, 3'd2, {$urandom, $urandom});
				// replace the degenerate rows, then exercise the real table
				queue_req(KIND_LOAD, '1, 3'd0, {$urandom, $urandom});
				queue_req(KIND_LOAD, '0, 3'd1, {$urandom, $urandom});
				queue_req(KIND_ENCRYPT, {1'b1, 63'd0}, 3'd5, {$urandom, $urandom});
				queue_req(KIND_DECRYPT, {1'b1, 63'd0}, 3'd3, {$urandom, $urandom});
				queue_req(KIND_ENCRYPT, 64'd1, 3'd0, '0);
				queue_req(KIND_DECRYPT, 64'd1, 3'd0, '0);
				queue_req(KIND_ENCRYPT, {$urandom, $urandom}, 3'd0, '0);
				queue_req(KIND_DECRYPT, {$urandom, $urandom}, 3'd0, '0);
				queue_req(KIND_ENCRYPT, '1, 3'd0, '0);
				queue_req(KIND_DECRYPT, '1, 3'd0, '0);
			end

			counted = 0;
			while (counted < RAND_PER_PHASE) begin
				r = random_req();
				cipher_reqs.push_back(r);
				if (r.op != KIND_UNUSED)
					counted++;
			end
		end

		wait_drained();
		$display("ran %0d encrypts, %0d decrypts and %0d row loads (%0d ignored items)",
			n_encrypts, n_decrypts, n_loads, n_ignored);
		$display("checked %0d results over %0d key settings, %0d errors",
			n_results, n_key_sets, n_errors);
		if (n_errors == 0 && blocks_due.size() == 0)
			$display("gost_block_cipher_ecb_top regression: pass");
		else
			$display("gost_block_cipher_ecb_top regression: fail");
		$finish;
	end

endmodule

// File: files.f
rtl/gbc_pkg.sv
rtl/gost_block_cipher_ecb_top.sv
dv/tb.sv
